// ===== rtl/core/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph pixel compositor package
// Shared types, constants and blend arithmetic for the compositor core.
// ----------------------------------------------------------------------------
package gpc_pkg;

  // Default number of palette entries.
  localparam int PAL_DEPTH_DEFAULT = 256;

  // One palette entry: byte 0 in bits 7:0, byte 1 in 15:8, byte 2 in 23:16.
  localparam int PAL_WIDTH = 24;

  // Mask values above this threshold mean full coverage.
  localparam logic [7:0] MASK_FULL_LIMIT = 8'd15;

  // Alpha reported by overlay mode for full coverage.
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    CMD_LOAD_PAL = 3'd0,
    CMD_MONO     = 3'd1,
    CMD_PALETTE  = 3'd2,
    CMD_REDSCALE = 3'd3,
    CMD_SEPARATE = 3'd4,
    CMD_OVERLAY  = 3'd5
  } command_t;

  // Blend weight min(mask,15)*16-8, valid for a nonzero mask.
  function automatic logic [7:0] glyph_alpha(input logic [7:0] mask);
    logic [3:0] clamp;
    clamp = (mask > MASK_FULL_LIMIT) ? 4'hF : mask[3:0];
    return {clamp - 4'd1, 4'h8};
  endfunction

  // ((a+1)*src + (256-a)*dst) >> 8. The weights sum to 257, so the
  // sum never exceeds 16 bits.
  function automatic logic [7:0] blend_ch(input logic [7:0] src,
                                          input logic [7:0] dst,
                                          input logic [7:0] alpha);
    logic [8:0]  w_src;
    logic [8:0]  w_dst;
    logic [16:0] p_src;
    logic [16:0] p_dst;
    logic [16:0] sum;
    w_src = {1'b0, alpha} + 9'd1;
    w_dst = 9'd256 - {1'b0, alpha};
    p_src = {8'b0, w_src} * {9'b0, src};
    p_dst = {8'b0, w_dst} * {9'b0, dst};
    sum   = p_src + p_dst;
    return sum[15:8];
  endfunction

endpackage

// ===== rtl/core/gpc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/glyph_pixel_compositor_core.sv =====
// ----------------------------------------------------------------------------
// Glyph pixel compositor core
// Blends one text glyph pixel into an RGB888 destination pixel per item.
// ----------------------------------------------------------------------------
// The core takes one item per clock while in_ready is high and returns
// exactly one result item for every input item, including palette loads
// and unknown commands (whose results are all zero). The accepting edge
// loads the input register and starts the registered read of the palette
// memory. The output register is then loaded from the blend logic once it
// is empty or its item is taken. With out_ready held high the sustained
// rate is one item per cycle; in_ready drops only when both the input
// register and the output register hold items and the output is stalled.
// A palette load writes the memory at the edge at which it is accepted, so
// a palette lookup in the very next item already sees the new colour.
// Palette entries that were never loaded read back as arbitrary values.
module glyph_pixel_compositor_core #(
  parameter int PALETTE_DEPTH = gpc_pkg::PAL_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] command,
  input  logic [7:0] fg_level,
  input  logic [7:0] mask_level,
  input  logic [7:0] pix_0,
  input  logic [7:0] pix_1,
  input  logic [7:0] pix_2,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_0,
  output logic [7:0] out_1,
  output logic [7:0] out_2,
  output logic [7:0] out_alpha,
  output logic       write_color,
  output logic       write_mask,
  output logic [7:0] mask_out
);

  import gpc_pkg::*;

  localparam int         PAL_AW    = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

  // Handshake and pipeline control.
  logic in_fire;
  logic s1_valid;
  logic out_load;

  // Input register stage.
  logic [2:0] s1_cmd;
  logic [7:0] s1_fg;
  logic [7:0] s1_mask;
  logic [7:0] s1_pix0;
  logic [7:0] s1_pix1;
  logic [7:0] s1_pix2;
  logic       s1_pal_ok;

  // Palette memory.
  logic                 fg_in_range;
  logic                 pal_we;
  logic [PAL_AW-1:0]    pal_addr;
  logic [PAL_WIDTH-1:0] pal_wdata;
  logic [PAL_WIDTH-1:0] pal_rdata;

  // Blend results for the item in the input register.
  logic [PAL_WIDTH-1:0] pal_color;
  logic [7:0]           alpha;
  logic                 mask_full;
  logic [7:0]           res_0;
  logic [7:0]           res_1;
  logic [7:0]           res_2;
  logic [7:0]           res_alpha;
  logic                 res_wcolor;
  logic                 res_wmask;
  logic [7:0]           res_mask;

  // The input register can take an item when it is empty or when its
  // current item moves into the output register in the same cycle.
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_fire  = in_valid && in_ready;

  assign fg_in_range = ({1'b0, fg_level} < PAL_LIMIT);
  assign pal_addr    = fg_level[PAL_AW-1:0];
  assign pal_wdata   = {pix_2, pix_1, pix_0};
  assign pal_we      = in_fire && (command_t'(command) == CMD_LOAD_PAL) && fg_in_range;

  // The read is enabled only on acceptance, so the read data stays with
  // its item while the input register is stalled.
  gpc_ram #(
    .WIDTH (PAL_WIDTH),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_addr),
    .wdata (pal_wdata),
    .re    (in_fire),
    .raddr (pal_addr),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd    <= command;
      s1_fg     <= fg_level;
      s1_mask   <= mask_level;
      s1_pix0   <= pix_0;
      s1_pix1   <= pix_1;
      s1_pix2   <= pix_2;
      s1_pal_ok <= fg_in_range;
    end
  end

  // An index beyond the palette looks up colour zero.
  assign pal_color = s1_pal_ok ? pal_rdata : '0;
  assign alpha     = glyph_alpha(s1_mask);
  assign mask_full = (s1_mask > MASK_FULL_LIMIT);

  // Result selection. Every field a command does not drive is zero, and a
  // zero mask suppresses the write in all merged and overlay modes.
  always_comb begin
    res_0      = '0;
    res_1      = '0;
    res_2      = '0;
    res_alpha  = '0;
    res_wcolor = 1'b0;
    res_wmask  = 1'b0;
    res_mask   = '0;
    case (command_t'(s1_cmd))
      CMD_MONO: begin
        if (s1_mask != 8'd0) begin
          res_wcolor = 1'b1;
          if (mask_full) begin
            res_0 = s1_fg;
            res_1 = s1_fg;
            res_2 = s1_fg;
          end else begin
            res_0 = blend_ch(s1_fg, s1_pix0, alpha);
            res_1 = blend_ch(s1_fg, s1_pix1, alpha);
            res_2 = blend_ch(s1_fg, s1_pix2, alpha);
          end
        end
      end
      CMD_PALETTE: begin
        // The palette colour is applied in reversed byte order.
        if (s1_mask != 8'd0) begin
          res_wcolor = 1'b1;
          res_0 = blend_ch(pal_color[23:16], s1_pix0, alpha);
          res_1 = blend_ch(pal_color[15:8], s1_pix1, alpha);
          res_2 = blend_ch(pal_color[7:0], s1_pix2, alpha);
        end
      end
      CMD_REDSCALE: begin
        if (s1_mask != 8'd0) begin
          res_wcolor = 1'b1;
          res_0 = mask_full ? s1_fg : blend_ch(s1_fg, s1_pix0, alpha);
        end
      end
      CMD_SEPARATE: begin
        if (s1_fg != 8'd0) begin
          res_wcolor = 1'b1;
          res_0 = s1_fg;
          res_1 = s1_fg;
          res_2 = s1_fg;
        end
        if (s1_mask != 8'd0) begin
          res_wmask = 1'b1;
          res_mask  = s1_mask;
        end
      end
      CMD_OVERLAY: begin
        if (s1_mask != 8'd0) begin
          res_wcolor = 1'b1;
          res_0      = s1_pix0;
          res_1      = s1_pix1;
          res_2      = s1_pix2;
          res_alpha  = mask_full ? ALPHA_OPAQUE : alpha;
        end
      end
      default: begin
        // Palette loads and unknown commands give an all-zero result.
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_0       <= res_0;
      out_1       <= res_1;
      out_2       <= res_2;
      out_alpha   <= res_alpha;
      write_color <= res_wcolor;
      write_mask  <= res_wmask;
      mask_out    <= res_mask;
    end
  end

  // An item in the input register always moves on when the output is empty.
  a_s1_drains: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("input register item did not reach the empty output register");

  // The core only refuses input when both stages are occupied.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid)
    else $error("input refused while a pipeline stage is empty");

  // Mask plane writes come only from separate mode, which has no alpha.
  a_mask_no_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_mask |-> out_alpha == 8'd0)
    else $error("mask plane write carries an overlay alpha");

  // A nonzero alpha only comes from overlay mode, which writes colour only.
  a_alpha_overlay: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_alpha != 8'd0) |-> write_color && !write_mask)
    else $error("overlay alpha without a colour-only write");

endmodule
